/* design/pss_pkg.sv */
// Shared types, field widths, command codes and the push bonus table
// for the priority sweep stack scheduler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    // Field widths on the stream ports
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = 12;
    localparam int PRIO_W      = 7;
    localparam int PROG_W      = 7;
    localparam int LEVEL_OUT_W = 7;
    localparam int S_TDATA_W   = 32;   // entry, move_priority, progress, zero pad
    localparam int M_TDATA_W   = 24;   // entry_out, level_out, zero pad

    // Parameter defaults
    localparam int LEVELS_DEF       = 128;
    localparam int ENTRIES_DEF      = 4096;
    localparam int PROGRESS_MAX_DEF = 104;

    // Command codes carried in tuser
    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Bonus = round(0.0032n^2 + 0.32n - 3) in exact integer form
    localparam int BONUS_W     = 10;
    localparam int BONUS_TAB_N = 256;
    localparam int BONUS_SQ    = 32;
    localparam int BONUS_LIN   = 3200;
    localparam int BONUS_BIAS  = 5000;
    localparam int BONUS_DEN   = 10000;
    localparam int BONUS_OFS   = 3;

    // Handle reduction counter (at most eight shifted subtracts)
    localparam int RED_K_W = 3;

    typedef logic [BONUS_TAB_N-1:0][BONUS_W-1:0] t_bonus_tab;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RED,
        S_PUSH_LVL,
        S_PUSH_WR,
        S_SWEEP,
        S_POP_LINK,
        S_POP_WB,
        S_POP_LOWER,
        S_EMIT
    } t_state;

    // Elaboration-time table, one signed entry per progress value
    function automatic t_bonus_tab build_bonus_tab();
        t_bonus_tab tab;
        int v;
        for (int n = 0; n < BONUS_TAB_N; n++) begin
            v = BONUS_SQ * n * n + BONUS_LIN * n + BONUS_BIAS;
            tab[n] = BONUS_W'(v / BONUS_DEN - BONUS_OFS);
        end
        return tab;
    endfunction

    localparam t_bonus_tab BONUS_TAB = build_bonus_tab();

    // Number of shifted subtracts needed to fold a handle below the store size
    function automatic int red_steps(int entries);
        int k;
        k = 0;
        while ((entries << k) <= ((1 << ENTRY_W) - 1)) begin
            k++;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* design/pss_level_calc.sv */
// Push level computation: progress saturation, bonus lookup, add and clamp.
// Depends on pss_pkg for the bonus table and field widths.
`timescale 1ns / 1ps
`default_nettype none

module pss_level_calc #(
    parameter int LEVELS       = pss_pkg::LEVELS_DEF,
    parameter int PROGRESS_MAX = pss_pkg::PROGRESS_MAX_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [pss_pkg::PRIO_W-1:0] i_move_priority,
    input  wire logic        [pss_pkg::PROG_W-1:0] i_progress,
    output logic             [$clog2(LEVELS)-1:0]  o_level
);
    import pss_pkg::*;

    localparam int LW    = $clog2(LEVELS);
    localparam int N_W   = $clog2(BONUS_TAB_N);
    localparam int SUM_W = BONUS_W + 1;

    logic        [N_W-1:0]     w_n;
    logic signed [BONUS_W-1:0] w_bonus;
    logic signed [SUM_W-1:0]   w_sum;
    logic        [LW-1:0]      w_level;
    logic        [LW-1:0]      r_level;

    // saturate progress, then look up the bonus
    assign w_n = (N_W'(i_progress) > N_W'(PROGRESS_MAX)) ? N_W'(PROGRESS_MAX)
                                                         : N_W'(i_progress);
    assign w_bonus = $signed(BONUS_TAB[w_n]);
    assign w_sum   = SUM_W'(i_move_priority) + SUM_W'(w_bonus);

    // clamp to the level range
    always_comb begin
        priority if (w_sum < 0) begin
            w_level = '0;
        end else if (w_sum > $signed(SUM_W'(LEVELS - 1))) begin
            w_level = LW'(LEVELS - 1);
        end else begin
            w_level = LW'(w_sum);
        end
    end

    // held until the next push transfer
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_level <= w_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

/* design/priority_sweep_stack_scheduler.sv */
// Top level of the priority sweep stack scheduler: command FSM, level head
// store, entry link store and result register. Uses pss_pkg, pss_level_calc.
//
//  Channel  Dir  Signals                              Transfer carries
//  -------  ---  -----------------------------------  ---------------------------------
//  s        in   i_s_tvalid o_s_tready i_s_tdata/tuser  push / pop / clear command
//  m        out  o_m_tvalid i_m_tready o_m_tdata/tuser  pop result
//
//  Push: handle fold steps when ENTRIES < 4096, then level lookup and write.
//  Clear: valid flags drop at once. Pop: a sweep over the levels, head and
//  link reads, head write-back, lowering of an emptied top level, then the
//  result; the sweep over the per-level valid flags is the long part.
//  One command at a time; a waiting result does not block the next command
//  until a second pop result is ready. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module priority_sweep_stack_scheduler #(
    parameter int LEVELS       = pss_pkg::LEVELS_DEF,
    parameter int ENTRIES      = pss_pkg::ENTRIES_DEF,
    parameter int PROGRESS_MAX = pss_pkg::PROGRESS_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [11:0] entry, [18:12] move_priority, [25:19] progress, [31:26] zero
    input  wire logic [pss_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [1:0] kind
    input  wire logic [pss_pkg::KIND_W-1:0]      i_s_tuser,
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [11:0] entry_out, [18:12] level_out, [23:19] zero
    output logic [pss_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // [0] found
    output logic                                 o_m_tuser
);
    import pss_pkg::*;

    localparam int LW        = $clog2(LEVELS);
    localparam int EW        = $clog2(ENTRIES);
    localparam int SW        = LW + 2;
    localparam int RED_STEPS = red_steps(ENTRIES);

    // ---------------- registers ----------------
    t_state                    r_state, n_state;
    logic        [LEVELS-1:0]  r_head_vld, n_head_vld;
    logic        [LW-1:0]      r_top, n_top;
    logic        [LW-1:0]      r_cursor, n_cursor;
    logic        [LW-1:0]      r_floor, n_floor;
    logic signed [SW-1:0]      r_q, n_q;
    logic signed [SW-1:0]      r_fl, n_fl;
    logic                      r_last, n_last;
    logic        [ENTRY_W-1:0] r_e, n_e;
    logic        [RED_K_W-1:0] r_red_k, n_red_k;
    logic        [EW-1:0]      r_pop_e, n_pop_e;
    logic        [LW-1:0]      r_taken, n_taken;
    logic                      r_found, n_found;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_found, n_out_found;
    logic [ENTRY_W-1:0]        r_out_e, n_out_e;
    logic [LEVEL_OUT_W-1:0]    r_out_lvl, n_out_lvl;

    // ---------------- input field split ----------------
    logic        [KIND_W-1:0]  w_in_kind;
    logic        [ENTRY_W-1:0] w_in_entry;
    logic signed [PRIO_W-1:0]  w_in_prio;
    logic        [PROG_W-1:0]  w_in_prog;
    logic                      w_in_xfer;
    logic                      w_out_free;

    assign w_in_kind  = i_s_tuser;
    assign w_in_entry = i_s_tdata[ENTRY_W-1:0];
    assign w_in_prio  = $signed(i_s_tdata[ENTRY_W+PRIO_W-1:ENTRY_W]);
    assign w_in_prog  = i_s_tdata[ENTRY_W+PRIO_W+PROG_W-1:ENTRY_W+PRIO_W];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // ---------------- memories ----------------
    logic [EW-1:0] r_head_mem [LEVELS];
    logic [EW:0]   r_link_mem [ENTRIES];
    logic [EW-1:0] r_head_rd;
    logic [EW:0]   r_link_rd;
    logic          w_head_we;
    logic [LW-1:0] w_head_waddr;
    logic [EW-1:0] w_head_wdata;
    logic [LW-1:0] w_head_raddr;
    logic          w_link_we;

    // ---------------- push level ----------------
    logic [LW-1:0] w_lvl;

    pss_level_calc #(
        .LEVELS       (LEVELS),
        .PROGRESS_MAX (PROGRESS_MAX)
    ) u_level_calc (
        .i_clk           (i_clk),
        .i_en            (w_in_xfer && (w_in_kind == KIND_PUSH)),
        .i_move_priority (w_in_prio),
        .i_progress      (w_in_prog),
        .o_level         (w_lvl)
    );

    // handle fold: one shifted subtract per cycle
    logic [ENTRY_W:0] w_red_sub;
    assign w_red_sub = (ENTRY_W + 1)'(ENTRIES) << r_red_k;

    // ---------------- sweep step ----------------
    logic signed [SW-1:0] w_top_s;
    logic signed [SW-1:0] w_q_dec;
    logic signed [SW-1:0] w_fl_dec;
    logic                 w_wrap;
    logic signed [SW-1:0] w_q_next;
    logic signed [SW-1:0] w_fl_next;
    logic                 w_last_next;
    logic                 w_empty;
    logic [LW-1:0]        w_q_idx;
    logic                 w_hit;
    logic                 w_lower;

    assign w_top_s   = $signed({2'b00, r_top});
    assign w_q_dec   = r_q - SW'(1);
    assign w_fl_dec  = r_fl - SW'(1);
    assign w_wrap    = (w_q_dec < r_fl);
    assign w_empty   = w_wrap && r_last;
    assign w_q_next  = w_wrap ? w_top_s : w_q_dec;
    assign w_fl_next = !w_wrap ? r_fl : ((w_fl_dec < 0) ? w_top_s : w_fl_dec);
    assign w_last_next = w_wrap ? (w_fl_next == '0) : r_last;
    assign w_q_idx   = w_q_next[LW-1:0];
    assign w_hit     = (w_q_next >= 0) && (w_q_next < $signed(SW'(LEVELS)))
                       && r_head_vld[w_q_idx];

    // top level empties after a pop
    assign w_lower = !r_head_vld[r_q[LW-1:0]] && (r_q == w_top_s) && (r_top != '0);

    // ---------------- next state and datapath ----------------
    always_comb begin
        n_state     = r_state;
        n_head_vld  = r_head_vld;
        n_top       = r_top;
        n_cursor    = r_cursor;
        n_floor     = r_floor;
        n_q         = r_q;
        n_fl        = r_fl;
        n_last      = r_last;
        n_e         = r_e;
        n_red_k     = r_red_k;
        n_pop_e     = r_pop_e;
        n_taken     = r_taken;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_e     = r_out_e;
        n_out_lvl   = r_out_lvl;
        w_head_we    = 1'b0;
        w_head_waddr = r_q[LW-1:0];
        w_head_wdata = r_link_rd[EW-1:0];
        w_head_raddr = w_q_idx;
        w_link_we    = 1'b0;

        // result register drains on its own
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    priority case (w_in_kind)
                        KIND_PUSH: begin
                            n_e     = w_in_entry;
                            n_red_k = RED_K_W'(RED_STEPS - 1);
                            n_state = (RED_STEPS > 0) ? S_PUSH_RED : S_PUSH_LVL;
                        end
                        KIND_POP: begin
                            n_q     = $signed({2'b00, r_cursor});
                            n_fl    = $signed({2'b00, r_floor});
                            n_last  = 1'b0;
                            n_state = S_SWEEP;
                        end
                        KIND_CLEAR: begin
                            n_head_vld = '0;
                            n_top      = '0;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            S_PUSH_RED: begin
                if ({1'b0, r_e} >= w_red_sub) begin
                    n_e = r_e - ENTRY_W'(w_red_sub);
                end
                n_red_k = r_red_k - RED_K_W'(1);
                if (r_red_k == '0) begin
                    n_state = S_PUSH_LVL;
                end
            end
            S_PUSH_LVL: begin
                // fetch the current head of the target level
                w_head_raddr = w_lvl;
                if (w_lvl > r_top) begin
                    n_top = w_lvl;
                end
                n_state = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                // old head goes under the new handle
                w_link_we    = 1'b1;
                w_head_we    = 1'b1;
                w_head_waddr = w_lvl;
                w_head_wdata = EW'(r_e);
                n_head_vld[w_lvl] = 1'b1;
                n_state = S_IDLE;
            end
            S_SWEEP: begin
                if (w_empty) begin
                    n_cursor = '0;
                    n_floor  = r_fl[LW-1:0];
                    n_found  = 1'b0;
                    n_state  = S_EMIT;
                end else begin
                    n_q    = w_q_next;
                    n_fl   = w_fl_next;
                    n_last = w_last_next;
                    if (w_hit) begin
                        n_taken = w_q_idx;
                        n_state = S_POP_LINK;
                    end
                end
            end
            S_POP_LINK: begin
                // head index read; link read issued from it
                n_pop_e = r_head_rd;
                n_state = S_POP_WB;
            end
            S_POP_WB: begin
                w_head_we = 1'b1;
                n_head_vld[r_q[LW-1:0]] = r_link_rd[EW];
                n_state = S_POP_LOWER;
            end
            S_POP_LOWER: begin
                if (w_lower) begin
                    n_top = r_top - LW'(1);
                    n_q   = w_q_dec;
                    if (w_q_dec < r_fl) begin
                        n_fl = w_q_dec;
                    end
                end else begin
                    n_cursor = r_q[LW-1:0];
                    n_floor  = r_fl[LW-1:0];
                    n_found  = 1'b1;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_e     = r_found ? ENTRY_W'(r_pop_e) : '0;
                    n_out_lvl   = r_found ? LEVEL_OUT_W'(r_taken) : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_vld  <= '0;
            r_top       <= '0;
            r_cursor    <= '0;
            r_floor     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head_vld  <= n_head_vld;
            r_top       <= n_top;
            r_cursor    <= n_cursor;
            r_floor     <= n_floor;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_fl        <= n_fl;
        r_last      <= n_last;
        r_e         <= n_e;
        r_red_k     <= n_red_k;
        r_pop_e     <= n_pop_e;
        r_taken     <= n_taken;
        r_found     <= n_found;
        r_out_found <= n_out_found;
        r_out_e     <= n_out_e;
        r_out_lvl   <= n_out_lvl;
    end

    // level head store: index of each level's top handle
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head_mem[w_head_waddr] <= w_head_wdata;
        end
        r_head_rd <= r_head_mem[w_head_raddr];
    end

    // entry link store: {valid, index} of the handle below
    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[EW'(r_e)] <= {r_head_vld[w_lvl], r_head_rd};
        end
        r_link_rd <= r_link_mem[r_head_rd];
    end

    // ---------------- outputs ----------------
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = {(M_TDATA_W - ENTRY_W - LEVEL_OUT_W)'(0), r_out_lvl, r_out_e};

    // ---------------- checks ----------------
    logic [LEVELS-1:0] w_vld_above;
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            w_vld_above[i] = r_head_vld[i] && (LW'(i) > r_top);
        end
    end

    // nothing is held above the top level between commands
    a_top_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_vld_above == '0))
        else $error("level above top_level holds a handle");

    // an empty report means every level is empty
    a_empty_true: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_found) |-> (r_head_vld == '0))
        else $error("empty pop reported while a level holds a handle");

    // the level being popped was non-empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_LINK) |-> r_head_vld[r_q[LW-1:0]])
        else $error("pop taken from an empty level");

    // folded handle fits the link store
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH_WR) |-> (32'(r_e) < 32'(ENTRIES)))
        else $error("pushed handle not folded below ENTRIES");

    // a pop result enters the register only when it is free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_m_tready) |=> (r_state == S_EMIT))
        else $error("pop result left while the result register was full");

endmodule

`default_nettype wire
